>>> rtl/tpp_pkg.sv
// Shared types, character codes and per-character scan functions for the
// two-number text request parser. No dependencies.
package tpp_pkg;

  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned CHAR_BITS  = 8;
  localparam int unsigned WIDE_BITS  = VALUE_BITS + 4;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [CHAR_BITS-1:0]  char_t;

  localparam char_t CH_NUL     = 8'h00;
  localparam char_t CH_TAB     = 8'h09;
  localparam char_t CH_LF      = 8'h0A;
  localparam char_t CH_SPACE   = 8'h20;
  localparam char_t CH_PLUS    = 8'h2B;
  localparam char_t CH_ZERO    = 8'h30;
  localparam char_t CH_NINE    = 8'h39;
  localparam char_t CH_UPPER_A = 8'h41;
  localparam char_t CH_UPPER_F = 8'h46;
  localparam char_t CH_UPPER_X = 8'h58;
  localparam char_t CH_LOWER_A = 8'h61;
  localparam char_t CH_LOWER_F = 8'h66;
  localparam char_t CH_LOWER_X = 8'h78;

  localparam logic [4:0] DIGIT_NONE = 5'd16;

  typedef enum logic [1:0] {
    PHASE_NONE,
    PHASE_ONE,
    PHASE_TWO
  } phase_e;

  typedef enum logic [2:0] {
    PFX_START,
    PFX_PLUS,
    PFX_ZERO,
    PFX_HEX_MARK,
    PFX_DIGITS
  } prefix_e;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_INVALID,
    STATUS_RANGE
  } status_e;

  typedef struct packed {
    phase_e  phase;
    logic    in_token;
    prefix_e prefix;
    radix_e  radix;
    value_t  acc;
    value_t  frame;
    value_t  pid;
    status_e err;
    logic    stopped;
  } scan_t;

  localparam scan_t SCAN_RESET = '{
    phase:    PHASE_NONE,
    in_token: 1'b0,
    prefix:   PFX_START,
    radix:    RADIX_DEC,
    acc:      '0,
    frame:    '0,
    pid:      '0,
    err:      STATUS_OK,
    stopped:  1'b0
  };

  typedef struct packed {
    logic  valid;
    char_t char_code;
    logic  last;
  } step_t;

  typedef struct packed {
    status_e status;
    word_t   frame_number;
    word_t   process_id;
    logic    pid_present;
  } result_t;

  function automatic logic [4:0] digit_of(char_t c);
    logic [4:0] d;
    d = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 5'(c - CH_ZERO);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      d = 5'(c - CH_LOWER_A) + 5'd10;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d = 5'(c - CH_UPPER_A) + 5'd10;
    end
    return d;
  endfunction

  function automatic scan_t scan_fail(scan_t s, status_e code);
    scan_t n;
    n = s;
    if (n.err == STATUS_OK) begin
      n.err = code;
    end
    n.stopped  = 1'b1;
    n.in_token = 1'b0;
    return n;
  endfunction

  function automatic scan_t scan_finish(scan_t s);
    scan_t n;
    n = s;
    if (n.in_token) begin
      n.in_token = 1'b0;
      if (n.prefix == PFX_START || n.prefix == PFX_PLUS || n.prefix == PFX_HEX_MARK) begin
        n = scan_fail(n, STATUS_INVALID);
      end else begin
        if (n.phase == PHASE_NONE) begin
          n.frame = n.acc;
          n.phase = PHASE_ONE;
        end else if (n.phase == PHASE_ONE) begin
          n.pid     = n.acc;
          n.phase   = PHASE_TWO;
          n.stopped = 1'b1;
        end
        n.prefix = PFX_START;
      end
    end
    return n;
  endfunction

  function automatic scan_t scan_feed(scan_t s, char_t c);
    scan_t                n;
    logic [4:0]           d;
    logic [4:0]           limit;
    logic [WIDE_BITS-1:0] acc_w;
    logic [WIDE_BITS-1:0] prod;
    logic [WIDE_BITS-1:0] sum;
    n     = s;
    d     = digit_of(c);
    acc_w = WIDE_BITS'(n.acc);
    unique case (n.radix)
      RADIX_HEX: begin
        limit = 5'd16;
        prod  = acc_w << 4;
      end
      RADIX_OCT: begin
        limit = 5'd8;
        prod  = acc_w << 3;
      end
      default: begin
        limit = 5'd10;
        prod  = (acc_w << 3) + (acc_w << 1);
      end
    endcase
    sum = prod + WIDE_BITS'(d);
    if (n.prefix == PFX_START && c == CH_PLUS) begin
      n.prefix = PFX_PLUS;
      return n;
    end
    if (n.prefix == PFX_START) begin
      n.prefix = PFX_PLUS;
    end
    unique case (n.prefix)
      PFX_PLUS: begin
        if (d == 5'd0) begin
          n.radix  = RADIX_OCT;
          n.acc    = '0;
          n.prefix = PFX_ZERO;
        end else if (d <= 5'd9) begin
          n.radix  = RADIX_DEC;
          n.acc    = VALUE_BITS'(d);
          n.prefix = PFX_DIGITS;
        end else begin
          n = scan_fail(n, STATUS_INVALID);
        end
      end
      PFX_ZERO: begin
        if (c == CH_LOWER_X || c == CH_UPPER_X) begin
          n.prefix = PFX_HEX_MARK;
        end else if (d < 5'd8) begin
          n.acc    = VALUE_BITS'(d);
          n.prefix = PFX_DIGITS;
        end else begin
          n = scan_fail(n, STATUS_INVALID);
        end
      end
      PFX_HEX_MARK: begin
        if (d < 5'd16) begin
          n.radix  = RADIX_HEX;
          n.acc    = VALUE_BITS'(d);
          n.prefix = PFX_DIGITS;
        end else begin
          n = scan_fail(n, STATUS_INVALID);
        end
      end
      PFX_DIGITS: begin
        if (d >= limit) begin
          n = scan_fail(n, STATUS_INVALID);
        end else if (|sum[WIDE_BITS-1:VALUE_BITS]) begin
          n = scan_fail(n, STATUS_RANGE);
        end else begin
          n.acc = sum[VALUE_BITS-1:0];
        end
      end
      default: begin
        n = scan_fail(n, STATUS_INVALID);
      end
    endcase
    return n;
  endfunction

endpackage

>>> rtl/tpp_req_if.sv
// Request channel: one text byte per item with its last marker.
// Depends on tpp_pkg.
interface tpp_req_if;
  logic                 valid;
  logic                 ready;
  tpp_pkg::char_t       char_code;
  logic                 last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

>>> rtl/tpp_res_if.sv
// Result channel: status and the two parsed numbers of one request.
// Depends on tpp_pkg.
interface tpp_res_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  tpp_pkg::word_t       frame_number;
  tpp_pkg::word_t       process_id;
  logic                 pid_present;

  modport source (output valid, output status, output frame_number, output process_id,
                  output pid_present, input ready);
  modport sink   (input valid, input status, input frame_number, input process_id,
                  input pid_present, output ready);
endinterface

>>> rtl/tpp_scan.sv
// Token scanner: holds the parse state and folds in one byte per cycle in
// which step_i is valid. Depends on tpp_pkg.
module tpp_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tpp_pkg::step_t   step_i,
  output tpp_pkg::result_t result_o
);
  import tpp_pkg::*;

  scan_t state_q;
  scan_t state_d;
  scan_t nxt;
  scan_t fin;

  always_comb begin
    nxt = state_q;
    if (!nxt.stopped) begin
      if (step_i.char_code == CH_NUL) begin
        nxt         = scan_finish(nxt);
        nxt.stopped = 1'b1;
      end else if (step_i.char_code == CH_SPACE || step_i.char_code == CH_TAB ||
                   step_i.char_code == CH_LF) begin
        nxt = scan_finish(nxt);
      end else begin
        if (!nxt.in_token) begin
          nxt.in_token = 1'b1;
          nxt.prefix   = PFX_START;
          nxt.radix    = RADIX_DEC;
          nxt.acc      = '0;
        end
        nxt = scan_feed(nxt, step_i.char_code);
      end
    end
    fin = nxt;
    if (!fin.stopped) begin
      fin = scan_finish(fin);
    end
  end

  always_comb begin
    result_o = '0;
    result_o.status = fin.err;
    if (fin.err == STATUS_OK && fin.phase == PHASE_NONE) begin
      result_o.status = STATUS_INVALID;
    end
    if (result_o.status == STATUS_OK) begin
      result_o.frame_number = WORD_BITS'(fin.frame);
      if (fin.phase == PHASE_TWO) begin
        result_o.process_id  = WORD_BITS'(fin.pid);
        result_o.pid_present = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    if (step_i.valid) begin
      state_d = step_i.last ? SCAN_RESET : nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SCAN_RESET;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/two_number_text_request_parser.sv
// Two-number text request parser, top level.
// Depends on tpp_pkg, tpp_req_if, tpp_res_if and tpp_scan.
//
// req_i carries one byte of request text per item, with last marking the
// final byte of a request. res_o gives one item per request: status, frame
// number, process id and pid_present.
// Each accepted byte lands in an input register; from there the scanner
// folds it into the parse state (one shift-add of the accumulator by the
// radix plus the overflow check). One byte is taken every cycle unless a
// last byte is held (see below). The result is registered when the last
// byte is scanned and offered from that register in the cycle after.
// While a result waits, ordinary bytes keep flowing; a further last byte
// holds in the input register, and req_i.ready drops, until res_o is taken.
// Reset clears the parse state and both valid flags; after each result the
// parse state returns to its reset value for the next request.
module two_number_text_request_parser (
  input  logic clk_i,
  input  logic rst_ni,
  tpp_req_if.sink   req_i,
  tpp_res_if.source res_o
);
  import tpp_pkg::*;

  logic    in_valid_q;
  logic    in_valid_d;
  char_t   in_char_q;
  logic    in_last_q;
  logic    out_valid_q;
  logic    out_valid_d;
  result_t out_q;
  logic    advance;
  step_t   step;
  result_t result;

  assign advance     = in_valid_q && (!in_last_q || !out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  assign step.valid     = advance;
  assign step.char_code = in_char_q;
  assign step.last      = in_last_q;

  tpp_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .result_o (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (req_i.ready) begin
      in_valid_d = req_i.valid;
    end
    out_valid_d = out_valid_q && !res_o.ready;
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_char_q <= req_i.char_code;
      in_last_q <= req_i.last;
    end
    if (advance && in_last_q) begin
      out_q <= result;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = out_q.status;
  assign res_o.frame_number = out_q.frame_number;
  assign res_o.process_id   = out_q.process_id;
  assign res_o.pid_present  = out_q.pid_present;

endmodule

>>> verif/tpp_parse_checker.sv
`timescale 1ns / 100ps
// Checker for the two-number text request parser: watches the request and
// result channels, predicts each result from the accepted text bytes and
// compares it field by field. Depends on tpp_pkg, tpp_req_if and tpp_res_if.
module tpp_parse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpp_req_if          req_i,
  tpp_res_if          res_i,
  output int unsigned fault_count_o,
  output int unsigned pending_count_o
);
  import tpp_pkg::*;

  localparam value_t VALUE_MAX = '1;

  phase_e      scan_phase;
  logic        in_word;
  prefix_e     lead_state;
  radix_e      base_sel;
  value_t      partial;
  value_t      first_num;
  value_t      second_num;
  status_e     first_err;
  logic        frozen;
  result_t     expected_replies[$];
  int unsigned faults;

  function automatic int unsigned digit_weight(char_t c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return 32'(c - CH_ZERO);
    end
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      return 32'(c - CH_LOWER_A) + 10;
    end
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      return 32'(c - CH_UPPER_A) + 10;
    end
    return 16;
  endfunction

  function automatic void clear_scan();
    scan_phase = PHASE_NONE;
    in_word    = 1'b0;
    lead_state = PFX_START;
    base_sel   = RADIX_DEC;
    partial    = '0;
    first_num  = '0;
    second_num = '0;
    first_err  = STATUS_OK;
    frozen     = 1'b0;
  endfunction

  function automatic void abort_scan(status_e code);
    if (first_err == STATUS_OK) begin
      first_err = code;
    end
    frozen  = 1'b1;
    in_word = 1'b0;
  endfunction

  function automatic void close_word();
    if (!in_word) begin
      return;
    end
    in_word = 1'b0;
    if (lead_state == PFX_START || lead_state == PFX_PLUS || lead_state == PFX_HEX_MARK) begin
      abort_scan(STATUS_INVALID);
      return;
    end
    if (scan_phase == PHASE_NONE) begin
      first_num  = partial;
      scan_phase = PHASE_ONE;
    end else if (scan_phase == PHASE_ONE) begin
      second_num = partial;
      scan_phase = PHASE_TWO;
      frozen     = 1'b1;
    end
    lead_state = PFX_START;
  endfunction

  function automatic void absorb_char(char_t c);
    int unsigned d;
    int unsigned base;
    d = digit_weight(c);
    if (lead_state == PFX_START) begin
      lead_state = PFX_PLUS;
      if (c == CH_PLUS) begin
        return;
      end
    end
    case (lead_state)
      PFX_PLUS: begin
        if (d == 0) begin
          base_sel   = RADIX_OCT;
          partial    = '0;
          lead_state = PFX_ZERO;
        end else if (d <= 9) begin
          base_sel   = RADIX_DEC;
          partial    = value_t'(d);
          lead_state = PFX_DIGITS;
        end else begin
          abort_scan(STATUS_INVALID);
        end
      end
      PFX_ZERO: begin
        if (c == CH_LOWER_X || c == CH_UPPER_X) begin
          lead_state = PFX_HEX_MARK;
        end else if (d < 8) begin
          partial    = value_t'(d);
          lead_state = PFX_DIGITS;
        end else begin
          abort_scan(STATUS_INVALID);
        end
      end
      PFX_HEX_MARK: begin
        if (d < 16) begin
          base_sel   = RADIX_HEX;
          partial    = value_t'(d);
          lead_state = PFX_DIGITS;
        end else begin
          abort_scan(STATUS_INVALID);
        end
      end
      PFX_DIGITS: begin
        base = (base_sel == RADIX_HEX) ? 16 : (base_sel == RADIX_OCT) ? 8 : 10;
        if (d >= base) begin
          abort_scan(STATUS_INVALID);
        end else if (partial > (VALUE_MAX - value_t'(d)) / value_t'(base)) begin
          abort_scan(STATUS_RANGE);
        end else begin
          partial = partial * value_t'(base) + value_t'(d);
        end
      end
      default: begin
        abort_scan(STATUS_INVALID);
      end
    endcase
  endfunction

  function automatic void scan_byte(char_t c, logic end_of_text);
    result_t reply;
    if (!frozen) begin
      if (c == CH_NUL) begin
        close_word();
        frozen = 1'b1;
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
        close_word();
      end else begin
        if (!in_word) begin
          in_word    = 1'b1;
          lead_state = PFX_START;
          base_sel   = RADIX_DEC;
          partial    = '0;
        end
        absorb_char(c);
      end
    end
    if (!end_of_text) begin
      return;
    end
    if (!frozen) begin
      close_word();
    end
    reply.status = first_err;
    if (first_err == STATUS_OK && scan_phase == PHASE_NONE) begin
      reply.status = STATUS_INVALID;
    end
    if (reply.status != STATUS_OK) begin
      reply.frame_number = '0;
      reply.process_id   = '0;
      reply.pid_present  = 1'b0;
    end else begin
      reply.frame_number = first_num;
      reply.process_id   = (scan_phase == PHASE_TWO) ? second_num : '0;
      reply.pid_present  = (scan_phase == PHASE_TWO);
    end
    expected_replies.push_back(reply);
    clear_scan();
  endfunction

  function automatic void report(string field, value_t want, value_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      faults++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      clear_scan();
      expected_replies.delete();
      faults = 0;
      fault_count_o   <= 0;
      pending_count_o <= 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        scan_byte(req_i.char_code, req_i.last);
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d %h %h %b", $time,
                   res_i.status, res_i.frame_number, res_i.process_id, res_i.pid_present);
          faults++;
        end else begin
          want = expected_replies.pop_front();
          report("status", value_t'(want.status), value_t'(res_i.status));
          report("frame_number", want.frame_number, res_i.frame_number);
          report("process_id", want.process_id, res_i.process_id);
          report("pid_present", value_t'(want.pid_present), value_t'(res_i.pid_present));
        end
      end
      fault_count_o   <= faults;
      pending_count_o <= expected_replies.size();
    end
  end

endmodule

>>> verif/tb_two_number_text_request_parser.sv
`timescale 1ns / 100ps
// Testbench top for the two-number text request parser: clock, reset, text
// stimulus with random idling on both channels, and the verdict.
// Depends on tpp_pkg, tpp_req_if, tpp_res_if, the parser and tpp_parse_checker.
module tb_two_number_text_request_parser;
  import tpp_pkg::*;

  localparam char_t       CH_MINUS     = 8'h2D;
  localparam char_t       CH_LOWER_G   = 8'h67;
  localparam char_t       CH_LOWER_Z   = 8'h7A;
  localparam char_t       CH_HIGH      = 8'hFF;
  localparam value_t      ALL_ONES     = '1;
  localparam int unsigned RANDOM_BYTES = 1100;
  localparam int unsigned CALM_BYTES   = 950;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fault_count;
  int unsigned pending_count;
  int unsigned sent_bytes;
  int unsigned send_rate;
  bit          calm;
  char_t       text_q[$];

  tpp_req_if req_if ();
  tpp_res_if res_if ();

  two_number_text_request_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  tpp_parse_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_if),
    .res_i           (res_if),
    .fault_count_o   (fault_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send_byte(char_t c, bit end_of_text);
    if (!calm && send_rate > 0 && $urandom_range(99) < send_rate) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.char_code <= c;
    req_if.last      <= end_of_text;
    do begin
      @(posedge clk_i);
    end while (!req_if.ready);
    sent_bytes++;
  endtask

  task automatic send_request();
    if (text_q.size() == 0) begin
      text_q.push_back(CH_SPACE);
    end
    foreach (text_q[i]) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(char_t'(s[i]));
    end
  endtask

  function automatic char_t pick_sep();
    case ($urandom_range(2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_LF;
    endcase
  endfunction

  task automatic push_seps(int unsigned lo, int unsigned hi);
    repeat ($urandom_range(hi, lo)) text_q.push_back(pick_sep());
  endtask

  function automatic int unsigned base_of(radix_e rx);
    return (rx == RADIX_HEX) ? 16 : (rx == RADIX_OCT) ? 8 : 10;
  endfunction

  function automatic char_t digit_char(int unsigned d);
    if (d < 10) begin
      return CH_ZERO + char_t'(d);
    end
    return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + char_t'(d - 10);
  endfunction

  task automatic put_digits(value_t v, radix_e rx);
    char_t       digs[$];
    value_t      base;
    base = value_t'(base_of(rx));
    do begin
      digs.push_front(digit_char(int'(v % base)));
      v = v / base;
    end while (v != 0);
    foreach (digs[i]) text_q.push_back(digs[i]);
  endtask

  task automatic push_number(value_t v, radix_e rx, bit plus);
    if (plus) begin
      text_q.push_back(CH_PLUS);
    end
    if (rx != RADIX_DEC) begin
      text_q.push_back(CH_ZERO);
    end
    if (rx == RADIX_HEX) begin
      text_q.push_back($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
      if ($urandom_range(3) == 0) begin
        text_q.push_back(CH_ZERO);
      end
    end
    put_digits(v, rx);
  endtask

  function automatic value_t random_value();
    case ($urandom_range(5))
      0:       return value_t'($urandom_range(99));
      1:       return value_t'($urandom);
      2:       return {$urandom, $urandom};
      3:       return {$urandom, $urandom} >> $urandom_range(63);
      4:       return ALL_ONES - value_t'($urandom_range(20));
      default: return '0;
    endcase
  endfunction

  function automatic radix_e random_radix();
    return radix_e'($urandom_range(2));
  endfunction

  task automatic push_good_token();
    push_number(random_value(), random_radix(), $urandom_range(4) == 0);
  endtask

  // near the top of the range: the appended digit may or may not overflow
  task automatic push_wide_token();
    radix_e      rx;
    int unsigned base;
    value_t      v;
    rx   = random_radix();
    base = base_of(rx);
    if ($urandom_range(1)) begin
      v = ALL_ONES / value_t'(base);
    end else begin
      v = {1'b1, 31'($urandom), $urandom};
    end
    push_number(v, rx, $urandom_range(4) == 0);
    text_q.push_back(digit_char($urandom_range(base - 1)));
    if ($urandom_range(3) == 0) begin
      text_q.push_back($urandom_range(1) ? CH_LOWER_Z : CH_MINUS);
    end
  endtask

  task automatic push_bad_token();
    char_t b;
    case ($urandom_range(8))
      0: begin
        text_q.push_back(CH_MINUS);
        push_good_token();
      end
      1: begin
        push_good_token();
        text_q.push_back(CH_MINUS);
        put_digits(value_t'($urandom_range(999)), RADIX_DEC);
      end
      2: begin
        text_q.push_back(CH_ZERO);
        put_digits(value_t'($urandom_range(7)), RADIX_OCT);
        text_q.push_back(CH_NINE - char_t'($urandom_range(1)));
      end
      3: begin
        push_number(value_t'($urandom), RADIX_DEC, 1'b0);
        text_q.push_back($urandom_range(1) ? digit_char($urandom_range(15, 10)) : CH_LOWER_G);
      end
      4: begin
        push_text($urandom_range(1) ? "0x" : "0X");
        text_q.push_back($urandom_range(1) ? CH_LOWER_G : CH_LOWER_Z);
      end
      5: begin
        text_q.push_back(CH_PLUS);
      end
      6: begin
        push_text($urandom_range(1) ? "0x" : "+0X");
      end
      7: begin
        push_text("++");
        put_digits(value_t'($urandom_range(99)), RADIX_DEC);
      end
      default: begin
        do begin
          b = char_t'($urandom_range(255, 1));
        end while (b == CH_SPACE || b == CH_TAB || b == CH_LF);
        if ($urandom_range(1)) begin
          push_good_token();
        end
        text_q.push_back(b);
      end
    endcase
  endtask

  task automatic push_token(bit bad, bit wide);
    if (bad) begin
      push_bad_token();
    end else if (wide) begin
      push_wide_token();
    end else begin
      push_good_token();
    end
  endtask

  task automatic build_request();
    int unsigned roll;
    int unsigned bad_at;
    int unsigned wide_at;
    roll = $urandom_range(99);
    if (roll < 3) begin
      push_seps(1, 4);
      return;
    end
    if (roll < 10) begin
      repeat ($urandom_range(12, 1)) text_q.push_back(char_t'($urandom_range(255)));
      return;
    end
    bad_at  = (roll < 28) ? $urandom_range(2, 1) : 0;
    wide_at = (roll >= 28 && roll < 40) ? $urandom_range(2, 1) : 0;
    if ($urandom_range(3) == 0) begin
      push_seps(1, 3);
    end
    push_token(bad_at == 1, wide_at == 1);
    if (bad_at == 2 || wide_at == 2 || $urandom_range(99) < 65) begin
      push_seps(1, 3);
      push_token(bad_at == 2, wide_at == 2);
      if ($urandom_range(4) == 0) begin
        push_seps(1, 2);
        push_good_token();
      end
    end
    if ($urandom_range(1)) begin
      push_seps(1, 2);
    end
    if ($urandom_range(9) == 0) begin
      text_q.push_back(CH_NUL);
      repeat ($urandom_range(6)) text_q.push_back(char_t'($urandom_range(255)));
    end
  endtask

  task automatic send_directed();
    push_text("18446744073709551615 0xFFFFFFFFffffffff"); send_request();
    push_text("0");                                        send_request();
    push_text("+0x1f\t+077\n");                            send_request();
    push_text("18446744073709551616");                     send_request();
    push_text("0x10000000000000000");                      send_request();
    push_text("02000000000000000000000");                  send_request();
    push_text("01777777777777777777777 3\t00");            send_request();
    push_text("99999999999999999999z");                    send_request();
    push_text("-5");                                       send_request();
    push_text("12a 3");                                    send_request();
    push_text("09");                                       send_request();
    push_text("0x");                                       send_request();
    push_text("+");                                        send_request();
    push_text("+0x 1");                                    send_request();
    push_text("0xg");                                      send_request();
    push_text(" \t\n");                                    send_request();
    push_text("7 0X");                                     send_request();
    push_text("5 7 9");                                    send_request();
    push_text("++1");                                      send_request();
    push_text("  42  ");                                   send_request();
    push_text("5");
    text_q.push_back(CH_NUL);
    push_text(" -x");
    send_request();
    text_q.push_back(CH_NUL);
    send_request();
    push_text("8");
    text_q.push_back(CH_HIGH);
    push_text("1");
    send_request();
  endtask

  initial begin
    req_if.valid     <= 1'b0;
    req_if.char_code <= '0;
    req_if.last      <= 1'b0;
    sent_bytes = 0;
    send_rate  = 0;
    calm       = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    send_directed();
    wait_drained();
    begin
      int unsigned start;
      int unsigned requests;
      bit          paused;
      start    = sent_bytes;
      requests = 0;
      paused   = 1'b0;
      while (sent_bytes - start < RANDOM_BYTES) begin
        if (requests % 8 == 0) begin
          case ($urandom_range(3))
            0:       send_rate = 0;
            1:       send_rate = 10;
            2:       send_rate = 35;
            default: send_rate = 60;
          endcase
        end
        if (!paused && sent_bytes - start >= RANDOM_BYTES / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        calm = (sent_bytes - start >= CALM_BYTES);
        build_request();
        send_request();
        requests++;
      end
    end
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int unsigned stall_rate;
    int unsigned loops;
    int unsigned long_holds;
    res_if.ready <= 1'b0;
    stall_rate = 0;
    loops      = 0;
    long_holds = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (loops % 64 == 0) begin
        case ($urandom_range(3))
          0:       stall_rate = 0;
          1:       stall_rate = 5;
          2:       stall_rate = 20;
          default: stall_rate = 45;
        endcase
      end
      loops++;
      if (!calm && long_holds < 2 && loops % 400 == 0) begin
        res_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_holds++;
      end else if (!calm && $urandom_range(99) < stall_rate) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(17, 1)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

endmodule
